/* rtl/cau_pkg.sv */
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

	// Width of the exact sums of two 32x32 products.
	localparam int SUM_W = 66;

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_NEG  = 3'd4,
		CMD_MAG  = 3'd5,
		CMD_EQ   = 3'd6,
		CMD_PASS = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		IT_IDLE,
		IT_CHECK,
		IT_RUN,
		IT_DONE
	} it_state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic               eq;
	} qentry_t;

	typedef struct packed {
		logic                    is_mag;
		logic signed [SUM_W-1:0] n_re;
		logic signed [SUM_W-1:0] n_im;
		logic [63:0]             sumsq;
	} iter_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] re;
		logic [31:0] im;
		status_t     st;
	} iter_res_t;

endpackage

/* rtl/complex_arithmetic_unit_core.sv */
// Top level of the complex arithmetic unit: command queue front end and execution back end.
//
//  Channel   Handshake           Payload
//  -------   -----------------   ----------------------------------------
//  command   start / busy        cmd, a_re, a_im, b_re, b_im
//  result    done (one cycle)    res_re, res_im, is_equal, status
//
// An item is taken at a rising edge where start is high and busy is low.
// Add, subtract, multiply, negate, pass, equal and divide by zero run through
// the product and sum stages at one item per cycle while the iterative unit
// is idle; each passes the queue, both stages and the result register before
// its result strobe. Divide and magnitude run in the shared iterative unit,
// one quotient bit or one root bit per cycle, and the back end holds later
// items behind it, so results leave in the order items came in.
// Meanwhile the QUEUE_DEPTH-entry queue keeps taking items; busy is high
// only while the queue is full.
// The receiver cannot stall: done is high for exactly one cycle per item.
// Reset (arst_n low) empties the queue and pipeline and idles the iterative
// unit; no clearing pass is needed.
module complex_arithmetic_unit_core #(
	parameter int FRAC_BITS   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               is_equal,
	output cau_pkg::status_t   status
);
	import cau_pkg::*;

	logic    q_valid;
	logic    pop;
	qentry_t q_head;

	// The front end classifies each item and holds it until the back end pops it.
	cau_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.pop     (pop),
		.q_valid (q_valid),
		.q_head  (q_head)
	);

	// The back end pops an item whenever its first stage can move.
	cau_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.done     (done),
		.res_re   (res_re),
		.res_im   (res_im),
		.is_equal (is_equal),
		.status   (status)
	);

	// A zero divisor always yields a zero result.
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_DIV0) |-> (res_re == 0) && (res_im == 0))
		else $error("divide by zero result is not zero");

	// An equal match carries a clean zero result.
	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_equal |-> (status == ST_OK) && (res_re == 0) && (res_im == 0))
		else $error("equal result carries data or status");

	// The queue only fills when an item was offered.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an item");

endmodule

/* rtl/cau_front.sv */
// Front end: accepts commands, classifies them and queues them for the back end.
module cau_front #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	input  logic               pop,
	output logic               q_valid,
	output cau_pkg::qentry_t   q_head
);
	import cau_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	qentry_t         mem [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            push;
	qentry_t         entry;

	// Classification: the equality flag is settled here, so the back end
	// only has to carry it along.
	always_comb begin
		entry.cmd  = cmd_t'(cmd);
		entry.a_re = a_re;
		entry.a_im = a_im;
		entry.b_re = b_re;
		entry.b_im = b_im;
		entry.eq   = (cmd_t'(cmd) == CMD_EQ) && (a_re == b_re) && (a_im == b_im);
	end

	assign busy    = (count_q == CNTW'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign q_head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/cau_iter.sv */
// Iterative unit: two-lane restoring divider and rounded integer square root.
module cau_iter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cau_pkg::iter_req_t  req,
	output logic                busy,
	output cau_pkg::iter_res_t  res
);
	import cau_pkg::*;

	// Quotient bits needed: 32 integer bits plus FRAC_BITS+1 fraction bits.
	localparam int QW = FRAC_BITS + 33;
	localparam int CW = $clog2(QW + 1);
	localparam logic [QW:0] POS_LIM = (QW+1)'(32'h7FFF_FFFF);
	localparam logic [QW:0] NEG_LIM = (QW+1)'(32'h8000_0000);

	it_state_t state_q, state_d;

	logic          is_mag_q;
	logic          neg_re_q, neg_im_q;
	logic [63:0]   mag_re_q, mag_im_q;
	logic [63:0]   den_q;
	logic          ovf_re_q, ovf_im_q;
	logic [63:0]   rem_re_q, rem_im_q;
	logic [QW-1:0] q_re_q, q_im_q;
	logic [31:0]   sh_re_q, sh_im_q;
	logic [CW-1:0] cnt_q;
	logic [33:0]   sq_rem_q;
	logic [31:0]   sq_root_q;

	logic signed [SUM_W-1:0] abs_re, abs_im;
	logic [95:0]   lim;
	logic [64:0]   t_re, t_im;
	logic          ge_re, ge_im;
	logic [35:0]   t_sq, trial;
	logic          ge_sq;
	logic [32:0]   root_rnd;
	logic [32:0]   pk_re, pk_im;

	function automatic logic [32:0] pack_div(input logic neg, input logic ovf,
		input logic [QW-1:0] q);
		logic [QW:0]  m;
		logic [32:0]  r;
		m = ({1'b0, q} + 1'b1) >> 1;
		if (ovf) begin
			r = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
		end else if (!neg) begin
			r = (m > POS_LIM) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, m[31:0]};
		end else begin
			r = (m > NEG_LIM) ? {1'b1, 32'h8000_0000} : {1'b0, 32'd0 - m[31:0]};
		end
		return r;
	endfunction

	always_comb begin
		abs_re = req.n_re[SUM_W-1] ? -req.n_re : req.n_re;
		abs_im = req.n_im[SUM_W-1] ? -req.n_im : req.n_im;
		// Quotient integer part exceeds 2^31 exactly when mag >= den*(2^31+1).
		lim    = {1'b0, den_q, 31'd0} + {32'd0, den_q};
		t_re   = {rem_re_q, sh_re_q[31]};
		t_im   = {rem_im_q, sh_im_q[31]};
		ge_re  = t_re >= {1'b0, den_q};
		ge_im  = t_im >= {1'b0, den_q};
		t_sq   = {sq_rem_q, den_q[63:62]};
		trial  = {2'b00, sq_root_q, 2'b01};
		ge_sq  = t_sq >= trial;
		root_rnd = {1'b0, sq_root_q} + {32'd0, ({2'b00, sq_root_q} < sq_rem_q)};
		pk_re  = pack_div(neg_re_q, ovf_re_q, q_re_q);
		pk_im  = pack_div(neg_im_q, ovf_im_q, q_im_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IT_IDLE:  if (load) begin
				state_d = IT_CHECK;
			end
			IT_CHECK: state_d = IT_RUN;
			IT_RUN:   if (cnt_q == CW'(1)) begin
				state_d = IT_DONE;
			end
			IT_DONE:  state_d = IT_IDLE;
		endcase

		busy     = (state_q != IT_IDLE);
		res.done = (state_q == IT_DONE);
		if (is_mag_q) begin
			res.re = (root_rnd > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : root_rnd[31:0];
			res.im = '0;
			res.st = (root_rnd > 33'h0_7FFF_FFFF) ? ST_OVF : ST_OK;
		end else begin
			res.re = pk_re[31:0];
			res.im = pk_im[31:0];
			res.st = (pk_re[32] || pk_im[32]) ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IT_IDLE: if (load) begin
				is_mag_q <= req.is_mag;
				neg_re_q <= req.n_re[SUM_W-1];
				neg_im_q <= req.n_im[SUM_W-1];
				mag_re_q <= abs_re[63:0];
				mag_im_q <= abs_im[63:0];
				den_q    <= req.sumsq;
			end
			IT_CHECK: begin
				ovf_re_q  <= {32'd0, mag_re_q} >= lim;
				ovf_im_q  <= {32'd0, mag_im_q} >= lim;
				rem_re_q  <= {32'd0, mag_re_q[63:32]};
				rem_im_q  <= {32'd0, mag_im_q[63:32]};
				sh_re_q   <= mag_re_q[31:0];
				sh_im_q   <= mag_im_q[31:0];
				q_re_q    <= '0;
				q_im_q    <= '0;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				cnt_q     <= is_mag_q ? CW'(32) : CW'(QW);
			end
			IT_RUN: begin
				cnt_q <= cnt_q - 1'b1;
				if (is_mag_q) begin
					// One result bit per cycle from two radicand bits.
					sq_rem_q  <= ge_sq ? 34'(t_sq - trial) : t_sq[33:0];
					sq_root_q <= {sq_root_q[30:0], ge_sq};
					den_q     <= den_q << 2;
				end else begin
					rem_re_q <= ge_re ? 64'(t_re - {1'b0, den_q}) : t_re[63:0];
					rem_im_q <= ge_im ? 64'(t_im - {1'b0, den_q}) : t_im[63:0];
					q_re_q   <= {q_re_q[QW-2:0], ge_re};
					q_im_q   <= {q_im_q[QW-2:0], ge_im};
					sh_re_q  <= sh_re_q << 1;
					sh_im_q  <= sh_im_q << 1;
				end
			end
			IT_DONE: begin
			end
		endcase
	end

endmodule

/* rtl/cau_back.sv */
// Back end: product and sum stages, result rounding, iterative unit and result register.
module cau_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  cau_pkg::qentry_t   q_head,
	output logic               pop,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               is_equal,
	output cau_pkg::status_t   status
);
	import cau_pkg::*;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

	// Product stage.
	logic               v_s1;
	cmd_t               cmd_s1;
	logic signed [31:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic               eq_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [31:0] sq_x, sq_y;

	// Sum stage.
	logic                    v_s2;
	cmd_t                    cmd_s2;
	logic                    eq_s2;
	logic signed [SUM_W-1:0] re_s2, im_s2;
	logic [63:0]             sumsq_s2;
	logic signed [SUM_W-1:0] re_d, im_d;

	logic                    ld1, ld2, adv2, iter_op, fin;
	logic signed [SUM_W-1:0] rnd_re, rnd_im;
	logic [32:0]             sat_re, sat_im;

	iter_req_t ireq;
	iter_res_t ires;
	logic      it_busy;

	logic               done_q;
	logic signed [31:0] res_re_q, res_im_q;
	logic               eq_q;
	status_t            st_q;

	function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [32:0] r;
		if (v > SUM_W'(64'sd2147483647)) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -SUM_W'(64'sd2147483648)) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	assign iter_op = v_s2 && ((cmd_s2 == CMD_MAG) || ((cmd_s2 == CMD_DIV) && (sumsq_s2 != '0)));
	assign adv2    = v_s2 && !it_busy;
	assign fin     = adv2 && !iter_op;
	assign ld2     = v_s1 && (!v_s2 || adv2);
	assign ld1     = q_valid && (!v_s1 || ld2);
	assign pop     = ld1;

	assign sq_x = (q_head.cmd == CMD_MAG) ? q_head.a_re : q_head.b_re;
	assign sq_y = (q_head.cmd == CMD_MAG) ? q_head.a_im : q_head.b_im;

	always_ff @(posedge clk) begin
		if (ld1) begin
			cmd_s1  <= q_head.cmd;
			a_re_s1 <= q_head.a_re;
			a_im_s1 <= q_head.a_im;
			b_re_s1 <= q_head.b_re;
			b_im_s1 <= q_head.b_im;
			eq_s1   <= q_head.eq;
			p0_s1   <= q_head.a_re * q_head.b_re;
			p1_s1   <= q_head.a_im * q_head.b_im;
			p2_s1   <= q_head.a_re * q_head.b_im;
			p3_s1   <= q_head.a_im * q_head.b_re;
			p4_s1   <= sq_x * sq_x;
			p5_s1   <= sq_y * sq_y;
		end
	end

	always_comb begin
		re_d = '0;
		im_d = '0;
		unique case (cmd_s1)
			CMD_ADD: begin
				re_d = SUM_W'(a_re_s1) + SUM_W'(b_re_s1);
				im_d = SUM_W'(a_im_s1) + SUM_W'(b_im_s1);
			end
			CMD_SUB: begin
				re_d = SUM_W'(a_re_s1) - SUM_W'(b_re_s1);
				im_d = SUM_W'(a_im_s1) - SUM_W'(b_im_s1);
			end
			CMD_MUL: begin
				re_d = SUM_W'(p0_s1) - SUM_W'(p1_s1);
				im_d = SUM_W'(p2_s1) + SUM_W'(p3_s1);
			end
			CMD_DIV: begin
				// Numerator is a times the conjugate of b.
				re_d = SUM_W'(p0_s1) + SUM_W'(p1_s1);
				im_d = SUM_W'(p3_s1) - SUM_W'(p2_s1);
			end
			CMD_NEG: begin
				re_d = -SUM_W'(a_re_s1);
				im_d = -SUM_W'(a_im_s1);
			end
			CMD_MAG, CMD_EQ: begin
				re_d = '0;
				im_d = '0;
			end
			CMD_PASS: begin
				re_d = SUM_W'(a_re_s1);
				im_d = SUM_W'(a_im_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			cmd_s2   <= cmd_s1;
			eq_s2    <= eq_s1;
			re_s2    <= re_d;
			im_s2    <= im_d;
			sumsq_s2 <= $unsigned(p4_s1) + $unsigned(p5_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= 1'b1;
			end else if (ld2) begin
				v_s1 <= 1'b0;
			end
			if (ld2) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Products are rounded to nearest, ties away from zero, in one add.
	always_comb begin
		rnd_re = re_s2;
		rnd_im = im_s2;
		if (cmd_s2 == CMD_MUL) begin
			rnd_re = (re_s2 + HALF - $signed({{(SUM_W-1){1'b0}}, re_s2[SUM_W-1]})) >>> FRAC_BITS;
			rnd_im = (im_s2 + HALF - $signed({{(SUM_W-1){1'b0}}, im_s2[SUM_W-1]})) >>> FRAC_BITS;
		end
		sat_re = sat32(rnd_re);
		sat_im = sat32(rnd_im);
	end

	assign ireq.is_mag = (cmd_s2 == CMD_MAG);
	assign ireq.n_re   = re_s2;
	assign ireq.n_im   = im_s2;
	assign ireq.sumsq  = sumsq_s2;

	cau_iter #(
		.FRAC_BITS(FRAC_BITS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv2 && iter_op),
		.req    (ireq),
		.busy   (it_busy),
		.res    (ires)
	);

	always_ff @(posedge clk) begin
		if (ires.done) begin
			res_re_q <= ires.re;
			res_im_q <= ires.im;
			eq_q     <= 1'b0;
			st_q     <= ires.st;
		end else if (fin) begin
			if (cmd_s2 == CMD_DIV) begin
				res_re_q <= '0;
				res_im_q <= '0;
				eq_q     <= 1'b0;
				st_q     <= ST_DIV0;
			end else begin
				res_re_q <= sat_re[31:0];
				res_im_q <= sat_im[31:0];
				eq_q     <= eq_s2;
				st_q     <= (sat_re[32] || sat_im[32]) ? ST_OVF : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin || ires.done;
		end
	end

	assign done     = done_q;
	assign res_re   = res_re_q;
	assign res_im   = res_im_q;
	assign is_equal = eq_q;
	assign status   = st_q;

endmodule
